// ----- hw/rtl/wiegand_receiver_assert.svh -----
// ----------------------------------------------------------------------------
// Wiegand receiver assertion macros
// Shared property shorthands for the checker of the Wiegand receiver.
// ----------------------------------------------------------------------------
`ifndef WIEGAND_RECEIVER_ASSERT_SVH
`define WIEGAND_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WIEG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("Wiegand receiver check failed in the same cycle.");

// The consequent must hold in the cycle after the antecedent.
`define WIEG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("Wiegand receiver check failed in the following cycle.");

`endif

// ----- hw/rtl/wieg_pkg.sv -----
// ----------------------------------------------------------------------------
// Wiegand receiver package
// Widths, codes, stream item layouts and the frame phase type.
// ----------------------------------------------------------------------------
package wieg_pkg;

  localparam int SHIFT_WIDTH = 64;
  localparam int CNT_W       = $clog2(SHIFT_WIDTH + 1);

  localparam logic [2:0] MODE_D0    = 3'd0;
  localparam logic [2:0] MODE_D1    = 3'd1;
  localparam logic [2:0] MODE_TICK  = 3'd2;
  localparam logic [2:0] MODE_READ  = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;

  localparam logic [1:0] RX_IDLE     = 2'd0;
  localparam logic [1:0] RX_RECEIVE  = 2'd1;
  localparam logic [1:0] RX_COMPLETE = 2'd2;
  localparam logic [1:0] RX_ERROR    = 2'd3;

  localparam logic REG_GAP_TIMEOUT = 1'b0;
  localparam logic REG_BIT_LIMIT   = 1'b1;

  localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd25;
  localparam logic [6:0]  BIT_LIMIT_RESET   = 7'd64;
  localparam logic [6:0]  FRAME26_BITS      = 7'd26;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_RECV = 4'b0010,
    PH_DONE = 4'b0100,
    PH_ERR  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] now_ms;
    logic [2:0]  mode;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [1:0]  rx_state;
    logic [6:0]  bit_total;
    logic        parity_good;
    logic [7:0]  site_code;
    logic [31:0] card_id;
    logic        frame_done;
  } out_item_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    unique case (ph)
      PH_IDLE: code = RX_IDLE;
      PH_RECV: code = RX_RECEIVE;
      PH_DONE: code = RX_COMPLETE;
      PH_ERR:  code = RX_ERROR;
      default: code = RX_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ----- hw/rtl/wiegand_receiver.sv -----
// ----------------------------------------------------------------------------
// Wiegand receiver
// Collects D0/D1 pulses into a frame, ends it after a silent gap and decodes
// the card id, with a standard parity check for 26-bit frames.
// ----------------------------------------------------------------------------
// Each request carries one event (pulse, tick, read or clear) with its
// millisecond timestamp and produces exactly one response that reports the
// frame state after that event. A request is registered on entry, evaluated
// against the frame state and written into the output register, so the block
// takes one request per clock while the output side does not stall. The single
// frame state update per cycle sets this rate. Configuration writes are taken
// at any time but are meant to happen only while no request is in flight.
module wiegand_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, low bit up: mode[2:0], now_ms[34:3], zero fill[39:35].
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, low bit up: frame_done[0], card_id[32:1], site_code[40:33],
  // parity_good[41], bit_total[48:42], rx_state[50:49], zero fill[55:51].
  output logic [55:0] m_tdata
);

  logic [15:0] gap_timeout_ms;
  logic [6:0]  bit_limit;

  logic                             in_valid;
  wieg_pkg::in_item_t               in_item;
  logic                             advance;

  logic [wieg_pkg::SHIFT_WIDTH-1:0] shift_bits, shift_bits_next;
  logic [wieg_pkg::CNT_W-1:0]       bits_held, bits_held_next;
  logic [31:0]                      last_pulse_ms, last_pulse_ms_next;
  wieg_pkg::phase_t                 phase, phase_next;
  logic                             ready_flag, ready_flag_next;

  wieg_pkg::out_item_t              out_item, out_item_next;

  logic [31:0]                      gap;
  logic                             gap_expired;
  logic [6:0]                       eff_limit;
  logic [wieg_pkg::SHIFT_WIDTH-1:0] shift_start;
  logic [wieg_pkg::CNT_W-1:0]       count_start;
  logic [25:0]                      frame26;
  logic                             frame_done;
  logic [31:0]                      card_id;
  logic [7:0]                       site_code;
  logic                             parity_good;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tdata  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_timeout_ms <= wieg_pkg::GAP_TIMEOUT_RESET;
      bit_limit      <= wieg_pkg::BIT_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wieg_pkg::REG_GAP_TIMEOUT: gap_timeout_ms <= cfg_data;
        wieg_pkg::REG_BIT_LIMIT:   bit_limit      <= cfg_data[6:0];
        default:                   gap_timeout_ms <= gap_timeout_ms;
      endcase
    end
  end

  always_comb begin
    gap         = in_item.now_ms - last_pulse_ms;
    gap_expired = (phase == wieg_pkg::PH_RECV) && (gap > {16'd0, gap_timeout_ms});
    eff_limit   = (bit_limit > 7'(wieg_pkg::SHIFT_WIDTH)) ?
                  7'(wieg_pkg::SHIFT_WIDTH) : bit_limit;
    shift_start = gap_expired ? '0 : shift_bits;
    count_start = gap_expired ? '0 : bits_held;
    frame26     = shift_bits[25:0];

    shift_bits_next    = shift_bits;
    bits_held_next     = bits_held;
    last_pulse_ms_next = last_pulse_ms;
    phase_next         = phase;
    ready_flag_next    = ready_flag;
    frame_done         = 1'b0;
    card_id            = '0;
    site_code          = '0;
    parity_good        = 1'b0;

    unique case (in_item.mode)
      wieg_pkg::MODE_D0, wieg_pkg::MODE_D1: begin
        shift_bits_next = shift_start;
        bits_held_next  = count_start;
        if (gap_expired) begin
          phase_next = wieg_pkg::PH_IDLE;
        end
        if (7'(count_start) >= eff_limit) begin
          phase_next = wieg_pkg::PH_ERR;
        end else begin
          shift_bits_next    = {shift_start[wieg_pkg::SHIFT_WIDTH-2:0], in_item.mode[0]};
          bits_held_next     = count_start + 1'b1;
          last_pulse_ms_next = in_item.now_ms;
          phase_next         = wieg_pkg::PH_RECV;
          ready_flag_next    = 1'b0;
        end
      end
      wieg_pkg::MODE_TICK: begin
        if (gap_expired) begin
          if (bits_held != '0) begin
            phase_next      = wieg_pkg::PH_DONE;
            ready_flag_next = 1'b1;
            frame_done      = 1'b1;
          end else begin
            phase_next = wieg_pkg::PH_IDLE;
          end
        end
      end
      wieg_pkg::MODE_READ: begin
        if (ready_flag) begin
          if (7'(bits_held) == wieg_pkg::FRAME26_BITS) begin
            site_code   = frame26[24:17];
            card_id     = {8'd0, frame26[24:17], frame26[16:1]};
            parity_good = ((frame26[25] ^ (^frame26[24:13])) == 1'b0) &&
                          ((frame26[0] ^ (^frame26[12:1])) == 1'b1);
          end else if (7'(bits_held) >= 7'd2) begin
            card_id = 32'(shift_bits);
          end
          shift_bits_next    = '0;
          bits_held_next     = '0;
          last_pulse_ms_next = '0;
          phase_next         = wieg_pkg::PH_IDLE;
          ready_flag_next    = 1'b0;
        end
      end
      wieg_pkg::MODE_CLEAR: begin
        shift_bits_next    = '0;
        bits_held_next     = '0;
        last_pulse_ms_next = '0;
        phase_next         = wieg_pkg::PH_IDLE;
        ready_flag_next    = 1'b0;
      end
      default: begin
        phase_next = phase;
      end
    endcase

    out_item_next.pad         = '0;
    out_item_next.rx_state    = wieg_pkg::phase_code(phase_next);
    out_item_next.bit_total   = 7'(bits_held_next);
    out_item_next.parity_good = parity_good;
    out_item_next.site_code   = site_code;
    out_item_next.card_id     = card_id;
    out_item_next.frame_done  = frame_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
      shift_bits    <= '0;
      bits_held     <= '0;
      last_pulse_ms <= '0;
      phase         <= wieg_pkg::PH_IDLE;
      ready_flag    <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid      <= 1'b1;
        shift_bits    <= shift_bits_next;
        bits_held     <= bits_held_next;
        last_pulse_ms <= last_pulse_ms_next;
        phase         <= phase_next;
        ready_flag    <= ready_flag_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= wieg_pkg::in_item_t'(s_tdata);
    end
    if (advance) begin
      out_item <= out_item_next;
    end
  end

endmodule

// ----- hw/rtl/wieg_checker.sv -----
// ----------------------------------------------------------------------------
// Wiegand receiver checker
// Port-level properties of the Wiegand receiver, bound to its top level.
// ----------------------------------------------------------------------------
`include "wiegand_receiver_assert.svh"

module wieg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  wieg_pkg::out_item_t rsp;

  assign rsp = wieg_pkg::out_item_t'(m_tdata);

  `WIEG_ASSERT_NEXT(a_rsp_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  `WIEG_ASSERT_NOW(a_ready_only_on_stall, !s_tready, m_tvalid && !m_tready)

  `WIEG_ASSERT_NOW(a_done_is_complete, m_tvalid && rsp.frame_done,
    rsp.rx_state == wieg_pkg::RX_COMPLETE && rsp.card_id == 32'd0)

  `WIEG_ASSERT_NOW(a_decode_clears, m_tvalid && (rsp.parity_good || rsp.site_code != 8'd0),
    rsp.rx_state == wieg_pkg::RX_IDLE && rsp.bit_total == 7'd0)

  `WIEG_ASSERT_NOW(a_count_matches_state, m_tvalid,
    (rsp.rx_state == wieg_pkg::RX_IDLE) == (rsp.bit_total == 7'd0) ||
    rsp.rx_state == wieg_pkg::RX_ERROR)

endmodule

bind wiegand_receiver wieg_checker u_wieg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/sv/wiegand_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wiegand receiver checker
// Watches the register port and both stream channels of the receiver. It keeps
// its own copy of the frame state and settings, works out the report that each
// accepted request must produce, and compares every report field by field.
// ----------------------------------------------------------------------------
module wiegand_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  output int unsigned pending,
  output int unsigned fail_count,
  output int unsigned checked_count,
  output int unsigned frame_count,
  output int unsigned card26_count
);
  import wieg_pkg::*;

  logic [15:0]            gap_limit_ms;
  logic [6:0]             max_bits;
  logic [SHIFT_WIDTH-1:0] frame_bits;
  logic [6:0]             frame_len;
  logic [31:0]            last_pulse_at;
  logic [1:0]             rx_phase;
  logic                   card_ready;

  out_item_t   report_q[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned frames;
  int unsigned cards26;

  function automatic void clear_receiver();
    frame_bits    = '0;
    frame_len     = '0;
    last_pulse_at = '0;
    card_ready    = 1'b0;
    rx_phase      = RX_IDLE;
  endfunction

  function automatic out_item_t decode_event(input logic [2:0] mode, input logic [31:0] now);
    out_item_t   res;
    logic [31:0] gap;
    logic [6:0]  limit;
    logic [25:0] d;
    res = '0;
    gap = now - last_pulse_at;
    case (mode)
      MODE_D0, MODE_D1: begin
        limit = (max_bits > 7'(SHIFT_WIDTH)) ? 7'(SHIFT_WIDTH) : max_bits;
        if (rx_phase == RX_RECEIVE && gap > 32'(gap_limit_ms)) begin
          frame_bits = '0;
          frame_len  = '0;
          rx_phase   = RX_IDLE;
        end
        if (frame_len >= limit) begin
          rx_phase = RX_ERROR;
        end else begin
          frame_bits    = {frame_bits[SHIFT_WIDTH-2:0], mode[0]};
          frame_len     = frame_len + 7'd1;
          last_pulse_at = now;
          rx_phase      = RX_RECEIVE;
          card_ready    = 1'b0;
        end
      end
      MODE_TICK: begin
        if (rx_phase == RX_RECEIVE && gap > 32'(gap_limit_ms)) begin
          if (frame_len != 0) begin
            rx_phase       = RX_COMPLETE;
            card_ready     = 1'b1;
            res.frame_done = 1'b1;
            frames++;
          end else begin
            rx_phase = RX_IDLE;
          end
        end
      end
      MODE_READ: begin
        if (card_ready) begin
          if (frame_len == FRAME26_BITS) begin
            d               = frame_bits[25:0];
            res.site_code   = d[24:17];
            res.card_id     = {8'h00, d[24:1]};
            res.parity_good = (d[25] == ^d[24:13]) && (d[0] != ^d[12:1]);
            cards26++;
          end else if (frame_len >= 7'd2) begin
            res.card_id = frame_bits[31:0];
          end
          clear_receiver();
        end
      end
      MODE_CLEAR: clear_receiver();
      default: ;
    endcase
    res.bit_total = frame_len;
    res.rx_state  = rx_phase;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    in_item_t  req;
    out_item_t got;
    out_item_t want;
    if (rst) begin
      gap_limit_ms = GAP_TIMEOUT_RESET;
      max_bits     = BIT_LIMIT_RESET;
      clear_receiver();
      report_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAP_TIMEOUT: gap_limit_ms = cfg_data;
          REG_BIT_LIMIT:   max_bits     = cfg_data[6:0];
        endcase
      end
      if (s_tvalid && s_tready) begin
        req = in_item_t'(s_tdata);
        report_q.push_back(decode_event(req.mode, req.now_ms));
      end
      if (m_tvalid && m_tready) begin
        got = out_item_t'(m_tdata);
        if (report_q.size() == 0) begin
          $error("Report 0x%0h arrived with no request waiting for it.", m_tdata);
          errors++;
        end else begin
          want = report_q.pop_front();
          checked++;
          check_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
          check_field("card_id", want.card_id, got.card_id);
          check_field("site_code", 32'(want.site_code), 32'(got.site_code));
          check_field("parity_good", 32'(want.parity_good), 32'(got.parity_good));
          check_field("bit_total", 32'(want.bit_total), 32'(got.bit_total));
          check_field("rx_state", 32'(want.rx_state), 32'(got.rx_state));
        end
      end
    end
    pending       <= report_q.size();
    fail_count    <= errors;
    checked_count <= checked;
    frame_count   <= frames;
    card26_count  <= cards26;
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wiegand receiver testbench
// Drives pulse, tick, read and clear requests with millisecond timestamps into
// the receiver under several register settings, with random bursts on the
// request side and random stalls on the report side, and gives the verdict
// from the failure count and the pending report count of the checker.
// ----------------------------------------------------------------------------
module testbench;
  import wieg_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned checked_count;
  int unsigned frame_count;
  int unsigned card26_count;

  logic [31:0] clock_ms;
  int          gap_ms;
  int          bit_cap;
  int          sent;
  int          burst_left;
  int          settings_used;

  wiegand_receiver i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  wiegand_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .pending      (pending),
    .fail_count   (fail_count),
    .checked_count(checked_count),
    .frame_count  (frame_count),
    .card26_count (card26_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  // The report side cycles through stall patterns of its own.
  initial begin
    int cycle;
    int stall_kind;
    cycle      = 0;
    stall_kind = 0;
    m_tready   = 1'b0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle % 400 == 0) stall_kind = $urandom_range(0, 3);
      case (stall_kind)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= (cycle % 4 == 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic put_request(input logic [2:0] mode, input logic [31:0] t);
    in_item_t req;
    int       idle;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      idle = $urandom_range(0, 5);
      if (idle != 0) begin
        s_tvalid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    req        = '0;
    req.mode   = mode;
    req.now_ms = t;
    s_tvalid <= 1'b1;
    s_tdata  <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic apply_settings(input int gap, input int limit);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_GAP_TIMEOUT;
    cfg_data  <= 16'(gap);
    @(posedge clk);
    cfg_index <= REG_BIT_LIMIT;
    cfg_data  <= 16'(limit);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    gap_ms  = gap;
    bit_cap = limit;
    settings_used++;
  endtask

  function automatic int quiet_step();
    return $urandom_range(0, gap_ms / 4);
  endfunction

  task automatic pulse_bit(input logic b);
    clock_ms += quiet_step();
    put_request(b ? MODE_D1 : MODE_D0, clock_ms);
  endtask

  task automatic send_bits(input logic [63:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      if ($urandom_range(0, 9) == 0) begin
        clock_ms += quiet_step();
        put_request(MODE_TICK, clock_ms);
      end
      pulse_bit(bits[i % 64]);
    end
  endtask

  task automatic end_frame();
    clock_ms += gap_ms + 1 + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_ms));
    put_request(MODE_TICK, clock_ms);
  endtask

  task automatic quick_request(input logic [2:0] mode);
    clock_ms += quiet_step();
    put_request(mode, clock_ms);
  endtask

  function automatic logic [63:0] card_frame(input logic good);
    logic [25:0] d;
    d[24:1] = {8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))};
    d[25]   = ^d[24:13];
    d[0]    = ~^d[12:1];
    if (!good) d[$urandom_range(0, 25)] ^= 1'b1;
    return 64'(d);
  endfunction

  task automatic run_random(input int budget);
    int target;
    int pick;
    int len;
    target = sent + budget;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_bits(card_frame($urandom_range(0, 9) < 7), int'(FRAME26_BITS));
        if (pick < 5) quick_request(MODE_TICK);
        end_frame();
        quick_request(MODE_READ);
      end else if (pick < 62) begin
        if ($urandom_range(0, 4) == 0) len = bit_cap + $urandom_range(1, 3);
        else if ($urandom_range(0, 1) == 0) len = $urandom_range(1, (bit_cap < 8) ? bit_cap : 8);
        else len = $urandom_range(1, bit_cap);
        send_bits({$urandom(), $urandom()}, len);
        end_frame();
        quick_request(MODE_READ);
        if (len > bit_cap && $urandom_range(0, 3) != 0) quick_request(MODE_CLEAR);
      end else if (pick < 70) begin
        send_bits({$urandom(), $urandom()}, $urandom_range(1, 12));
        clock_ms += gap_ms + 1 + $urandom_range(0, gap_ms);
        send_bits(card_frame(1'b1), int'(FRAME26_BITS));
        end_frame();
        quick_request(MODE_READ);
      end else if (pick < 78) begin
        len = ($urandom_range(0, 1) == 0) ? bit_cap : $urandom_range(1, bit_cap);
        send_bits({$urandom(), $urandom()}, len);
        end_frame();
        pulse_bit($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 0) end_frame();
        quick_request(MODE_READ);
      end else if (pick < 86) begin
        repeat ($urandom_range(1, 4)) begin
          clock_ms = ($urandom_range(0, 1) == 0) ? $urandom() : clock_ms + quiet_step();
          put_request(3'($urandom_range(0, 7)), clock_ms);
        end
      end else if (pick < 92) begin
        case ($urandom_range(0, 2))
          0: quick_request(MODE_READ);
          1: quick_request(MODE_CLEAR);
          default: quick_request(MODE_TICK);
        endcase
      end else if (pick < 96) begin
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * gap_ms);
        send_bits(card_frame(1'b1), int'(FRAME26_BITS));
        end_frame();
        quick_request(MODE_READ);
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_GAP_TIMEOUT;
    cfg_data      = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    sent          = 0;
    burst_left    = 0;
    settings_used = 1;
    gap_ms        = int'(GAP_TIMEOUT_RESET);
    bit_cap       = int'(BIT_LIMIT_RESET);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: unused modes, a gap equal to the timeout, a timeout
    // across the time wrap, restart after a long gap and a pulse after
    // completion.
    put_request(MODE_READ, 32'h0000_0000);
    for (int m = int'(MODE_CLEAR) + 1; m < 8; m++) put_request(3'(m), 32'hFFFF_FFFF);
    put_request(MODE_D1, 32'hFFFF_FFF0);
    put_request(MODE_TICK, 32'hFFFF_FFF0 + 32'(GAP_TIMEOUT_RESET));
    put_request(MODE_TICK, 32'h0000_000A);
    put_request(MODE_READ, 32'h0000_000B);
    put_request(MODE_D0, 32'd100);
    put_request(MODE_D1, 32'd110);
    put_request(MODE_D0, 32'd200);
    put_request(MODE_TICK, 32'd300);
    put_request(MODE_D1, 32'd301);
    put_request(MODE_TICK, 32'd400);
    put_request(MODE_READ, 32'd401);
    put_request(MODE_CLEAR, 32'd402);
    clock_ms = 32'd500;
    run_random(225);

    // Overflow of a ready frame, read out of the error state, then a plain
    // overflow left only by a clear.
    apply_settings(1, 2);
    put_request(MODE_D1, 32'd1000);
    put_request(MODE_D1, 32'd1001);
    put_request(MODE_TICK, 32'd1003);
    put_request(MODE_D0, 32'd1003);
    put_request(MODE_READ, 32'd1004);
    put_request(MODE_D1, 32'd1005);
    put_request(MODE_D1, 32'd1005);
    put_request(MODE_D0, 32'd1005);
    put_request(MODE_TICK, 32'd1010);
    put_request(MODE_CLEAR, 32'd1010);
    clock_ms = 32'd2000;

    apply_settings(1, 26);
    run_random(225);
    apply_settings(65535, 64);
    run_random(225);
    apply_settings(300, 1);
    run_random(225);
    apply_settings(40, 33);
    run_random(225);
    apply_settings($urandom_range(2, 2000), $urandom_range(26, 64));
    run_random(225);

    wait_drained();
    repeat (10) @(posedge clk);
    if (pending != 0) $error("%0d reports never arrived.", pending);
    $display("Sent %0d requests under %0d register settings; %0d reports checked.",
             sent, settings_used, checked_count);
    $display("%0d frames completed and %0d 26-bit cards decoded.", frame_count, card26_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
